>>> src/gspm_pkg.sv
// Package for the gain / saturate / peak meter block.
// Holds shared types, register indexes and constants; no dependencies.
package gspm_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_GAIN       = 2'd0;
    localparam logic [1:0] REG_WIDTH_MODE = 2'd1;
    localparam logic [1:0] REG_CURVE      = 2'd2;
    localparam logic [1:0] REG_PEAK_SCALE = 2'd3;

    // Reset values of the registers
    localparam logic [15:0] GAIN_UNITY      = 16'd256;
    localparam logic        MODE_RESET      = 1'b1;
    localparam logic [2:0]  CURVE_RESET     = 3'd0;
    localparam logic [15:0] PEAK_SCALE_INIT = 16'd100;

    // Full scale per sample width
    localparam logic [14:0] FS_NARROW = 15'd127;
    localparam logic [14:0] FS_WIDE   = 15'd32767;

    // Sample width modes
    localparam logic MODE_NARROW = 1'b0;

    // Weighting curve codes
    localparam logic [2:0] CURVE_SQRT   = 3'd1;
    localparam logic [2:0] CURVE_ROOT4  = 3'd2;
    localparam logic [2:0] CURVE_ROOT8  = 3'd3;
    localparam logic [2:0] CURVE_SQUARE = 3'd4;
    localparam logic [2:0] CURVE_POW4   = 3'd5;
    localparam logic [2:0] CURVE_POW8   = 3'd6;

    // Width of the Q1.16 ratio (1.0 needs bit 16)
    localparam int RATIO_W = 17;
    // Width of the square root working registers
    localparam int SQ_W = 34;

    typedef struct packed {
        logic [15:0] gain;
        logic        width_mode;
        logic [2:0]  curve;
        logic [15:0] peak_scale;
    } t_cfg;

    // One queued word: clamped sample plus frame peak snapshot
    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        logic [14:0] peak;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_SQR,
        ST_SCALE
    } t_state;

endpackage

>>> src/gspm_front.sv
// Front end: takes input words, applies gain and symmetric clamp, tracks frame peak.
// Depends on gspm_pkg.
module gspm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gspm_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  logic [15:0]     i_sample,
    input  logic            i_last,
    input  logic            i_full,
    output logic            o_ready,
    output logic            o_push,
    output gspm_pkg::t_item o_item
);

    logic        neg;
    logic [16:0] mag;
    logic [14:0] fs;
    logic [15:0] g;
    logic [32:0] prod;
    logic [24:0] scaled;
    logic [14:0] clamped;
    logic [14:0] new_peak;
    logic [14:0] r_peak;

    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    // Magnitude and full scale by mode
    always_comb begin
        if (i_cfg.width_mode == gspm_pkg::MODE_NARROW) begin
            neg = i_sample[7];
            mag = neg ? (17'd256 - {9'd0, i_sample[7:0]}) : {9'd0, i_sample[7:0]};
            fs  = gspm_pkg::FS_NARROW;
        end else begin
            neg = i_sample[15];
            mag = neg ? (17'h10000 - {1'b0, i_sample}) : {1'b0, i_sample};
            fs  = gspm_pkg::FS_WIDE;
        end
    end

    // Gain (zero acts as unity), truncate, clamp
    always_comb begin
        g        = (i_cfg.gain == 16'd0) ? gspm_pkg::GAIN_UNITY : i_cfg.gain;
        prod     = {16'd0, mag} * {17'd0, g};
        scaled   = prod[32:8];
        clamped  = (scaled > {10'd0, fs}) ? fs : scaled[14:0];
        new_peak = (clamped > r_peak) ? clamped : r_peak;
    end

    always_comb begin
        o_item.sample = neg ? (16'd0 - {1'b0, clamped}) : {1'b0, clamped};
        o_item.last   = i_last;
        o_item.peak   = new_peak;
    end

    // Running frame peak, cleared after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= 15'd0;
        end else if (o_push) begin
            r_peak <= i_last ? 15'd0 : new_peak;
        end
    end

endmodule

>>> src/gspm_queue.sv
// Two-entry queue between front and back ends.
// Depends on gspm_pkg.
module gspm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gspm_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output gspm_pkg::t_item o_item
);

    gspm_pkg::t_item r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/gspm_back.sv
// Back end: passes samples on and computes the weighted peak level on frame ends.
// Depends on gspm_pkg; ratio to full scale by constant-divisor logic, serial square root.
module gspm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gspm_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    input  gspm_pkg::t_item i_item,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [15:0]     o_sample,
    output logic            o_last,
    output logic [15:0]     o_level
);

    localparam int RW = gspm_pkg::RATIO_W;
    localparam int SW = gspm_pkg::SQ_W;

    gspm_pkg::t_state r_state, n_state;

    logic [15:0]   r_sample, n_sample;
    logic [14:0]   r_pk, n_pk;
    logic [RW-1:0] r_w, n_w;
    logic [SW-1:0] r_sq_v, n_sq_v;
    logic [SW-1:0] r_sq_res, n_sq_res;
    logic [SW-1:0] r_sq_bit, n_sq_bit;
    logic [1:0]    r_iter, n_iter;
    logic          r_ovalid, n_ovalid;
    logic [15:0]   r_osample, n_osample;
    logic          r_olast, n_olast;
    logic [15:0]   r_olevel, n_olevel;

    logic          out_free;
    logic [RW-1:0] ratio_wide;
    logic [8:0]    pk4;
    logic [2:0]    narrow_fix;
    logic [RW-1:0] ratio_narrow;
    logic [RW-1:0] ratio;
    logic [SW-1:0] sq_t;
    logic [2*RW-1:0] sqr_p;
    logic [32:0]   scale_p;

    assign o_valid  = r_ovalid;
    assign o_sample = r_osample;
    assign o_last   = r_olast;
    assign o_level  = r_olevel;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gspm_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_pk      <= n_pk;
        r_w       <= n_w;
        r_sq_v    <= n_sq_v;
        r_sq_res  <= n_sq_res;
        r_sq_bit  <= n_sq_bit;
        r_iter    <= n_iter;
        r_osample <= n_osample;
        r_olast   <= n_olast;
        r_olevel  <= n_olevel;
    end

    // Ratio peak * 65536 / fs for the two fixed full scales.
    // Wide: fs = 2^15 - 1, so the ratio is 2p + floor(2p / fs), the tail is 0, 1 or 2.
    // Narrow: 65536 = 516 * 127 + 4, so the ratio is 516p + floor(4p / 127).
    always_comb begin
        ratio_wide   = {1'b0, r_pk, 1'b0} + {16'd0, r_pk[14]} + {16'd0, &r_pk};
        pk4          = {r_pk[6:0], 2'b00};
        narrow_fix   = {2'd0, pk4 >= 9'd127} + {2'd0, pk4 >= 9'd254}
                     + {2'd0, pk4 >= 9'd381} + {2'd0, pk4 >= 9'd508};
        ratio_narrow = {1'b0, r_pk[6:0], 9'd0} + {8'd0, pk4} + {14'd0, narrow_fix};
        ratio        = (i_cfg.width_mode == gspm_pkg::MODE_NARROW) ? ratio_narrow : ratio_wide;
    end

    // Next state and datapath
    always_comb begin
        n_state   = r_state;
        n_sample  = r_sample;
        n_pk      = r_pk;
        n_w       = r_w;
        n_sq_v    = r_sq_v;
        n_sq_res  = r_sq_res;
        n_sq_bit  = r_sq_bit;
        n_iter    = r_iter;
        n_ovalid  = r_ovalid;
        n_osample = r_osample;
        n_olast   = r_olast;
        n_olevel  = r_olevel;
        o_pop     = 1'b0;

        out_free = ~r_ovalid | i_ready;
        sq_t     = r_sq_res + r_sq_bit;
        sqr_p    = r_w * r_w;
        scale_p  = {16'd0, r_w} * {17'd0, i_cfg.peak_scale};

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        unique case (r_state)
            gspm_pkg::ST_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (!i_item.last) begin
                        n_ovalid  = 1'b1;
                        n_osample = i_item.sample;
                        n_olast   = 1'b0;
                        n_olevel  = 16'd0;
                    end else begin
                        n_sample = i_item.sample;
                        n_pk     = i_item.peak;
                        n_state  = gspm_pkg::ST_DIV;
                    end
                end
            end
            // Ratio to full scale, then pick the curve
            gspm_pkg::ST_DIV: begin
                n_w = ratio;
                case (i_cfg.curve)
                    gspm_pkg::CURVE_SQRT, gspm_pkg::CURVE_ROOT4,
                    gspm_pkg::CURVE_ROOT8: begin
                        n_iter   = i_cfg.curve[1:0];
                        n_sq_v   = {1'b0, ratio, 16'd0};
                        n_sq_res = '0;
                        n_sq_bit = SW'(1) << 32;
                        n_state  = gspm_pkg::ST_SQRT;
                    end
                    gspm_pkg::CURVE_SQUARE, gspm_pkg::CURVE_POW4,
                    gspm_pkg::CURVE_POW8: begin
                        n_iter  = 2'(i_cfg.curve - 3'd3);
                        n_state = gspm_pkg::ST_SQR;
                    end
                    default: n_state = gspm_pkg::ST_SCALE;
                endcase
            end
            // Integer square root of w << 16, two bits a cycle
            gspm_pkg::ST_SQRT: begin
                if (r_sq_v >= sq_t) begin
                    n_sq_v   = r_sq_v - sq_t;
                    n_sq_res = (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    n_sq_res = r_sq_res >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
                if (r_sq_bit[0]) begin
                    n_w = n_sq_res[RW-1:0];
                    if (r_iter == 2'd1) begin
                        n_state = gspm_pkg::ST_SCALE;
                    end else begin
                        n_iter   = r_iter - 2'd1;
                        n_sq_v   = {1'b0, n_sq_res[RW-1:0], 16'd0};
                        n_sq_res = '0;
                        n_sq_bit = SW'(1) << 32;
                    end
                end
            end
            // Power curves: w = (w * w) >> 16 per step
            gspm_pkg::ST_SQR: begin
                n_w    = sqr_p[32:16];
                n_iter = r_iter - 2'd1;
                if (r_iter == 2'd1) n_state = gspm_pkg::ST_SCALE;
            end
            gspm_pkg::ST_SCALE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_osample = r_sample;
                    n_olast   = 1'b1;
                    n_olevel  = scale_p[31:16];
                    n_state   = gspm_pkg::ST_IDLE;
                end
            end
            default: n_state = gspm_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> src/gain_saturate_peak_meter.sv
// Top level of the gain / saturate / peak meter: register port, front, queue, back.
// Depends on gspm_pkg, gspm_front, gspm_queue, gspm_back.
//
//  channel  | dir | handshake               | word
//  s_axis   | in  | s_axis_tvalid/tready    | tdata[15:0] in_sample, tlast frame_end
//  m_axis   | out | m_axis_tvalid/tready    | tdata[15:0] out_sample, [31:16] peak_level,
//           |     |                         | tlast out_last
//  apb      | in  | psel/penable/pready     | gain, width mode, curve, peak scale at 0,4,8,12
//
// A word that does not end a frame goes from the queue straight to the output
// register, so such words stream at one per cycle while the output is free and
// no frame end is pending. A frame's last word takes the ratio to full scale, then
// the serial square root per root or the squaring per power step, then scaling.
// Reset is synchronous, active low; it restores register defaults and empties the queue.
// The front stalls only when the two-entry queue is full; the output register
// holds its word until m_axis_tready.
module gain_saturate_peak_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] in_sample
    input  logic        s_axis_tlast,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] out_sample, [31:16] peak_level
    output logic        m_axis_tlast
);

    gspm_pkg::t_cfg  r_cfg;
    gspm_pkg::t_item push_item;
    gspm_pkg::t_item pop_item;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic            wr_en;
    logic [15:0]     out_sample;
    logic [15:0]     out_level;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain       <= gspm_pkg::GAIN_UNITY;
            r_cfg.width_mode <= gspm_pkg::MODE_RESET;
            r_cfg.curve      <= gspm_pkg::CURVE_RESET;
            r_cfg.peak_scale <= gspm_pkg::PEAK_SCALE_INIT;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                gspm_pkg::REG_GAIN:       r_cfg.gain       <= pwdata[15:0];
                gspm_pkg::REG_WIDTH_MODE: r_cfg.width_mode <= pwdata[0];
                gspm_pkg::REG_CURVE:      r_cfg.curve      <= pwdata[2:0];
                gspm_pkg::REG_PEAK_SCALE: r_cfg.peak_scale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[3:2])
            gspm_pkg::REG_GAIN:       prdata = {16'd0, r_cfg.gain};
            gspm_pkg::REG_WIDTH_MODE: prdata = {31'd0, r_cfg.width_mode};
            gspm_pkg::REG_CURVE:      prdata = {29'd0, r_cfg.curve};
            gspm_pkg::REG_PEAK_SCALE: prdata = {16'd0, r_cfg.peak_scale};
            default:                  prdata = 32'd0;
        endcase
    end

    gspm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_full   (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_item   (push_item)
    );

    gspm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    gspm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_item   (pop_item),
        .o_pop    (pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_sample (out_sample),
        .o_last   (m_axis_tlast),
        .o_level  (out_level)
    );

    assign m_axis_tdata = {out_level, out_sample};

`ifndef SYNTH
    // Level is zero on words that do not end a frame
    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:16] == 16'd0)
        else $error("peak level set on a word that does not end a frame");

    // Clamp is symmetric: most negative code never appears
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000)
        else $error("clamp produced the most negative code");

    // Queue never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("queue written while full");

    // Queue never popped while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !pop)
        else $error("queue read while empty");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for gain_saturate_peak_meter: gain, clamp and frame peak level.
// Drives sample words and APB register writes, predicts every output word in-line.
// Depends on gspm_pkg and the RTL of gain_saturate_peak_meter.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        logic [15:0] level;
    } t_out_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] in_sample
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] out_sample, [31:16] peak_level
    logic        m_axis_tlast;

    gain_saturate_peak_meter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // predictor copy of the registers and frame peak
    logic [15:0] cfg_gain;
    logic        cfg_mode;
    logic [2:0]  cfg_curve;
    logic [15:0] cfg_scale;
    logic [14:0] frame_peak;

    // input word taken at the last rising edge
    logic        in_taken;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        errors;
    int        words_sent;
    int        words_checked;
    int        frames_checked;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // integer square root, bit by bit
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] peak_level_of(input logic [14:0] pk, input logic [14:0] fs);
        logic [63:0] w;
        int n;
        w = ({49'd0, pk} << 16) / fs;
        if (w > 65536) w = 65536;
        n = 0;
        if (cfg_curve == gspm_pkg::CURVE_SQRT || cfg_curve == gspm_pkg::CURVE_ROOT4
            || cfg_curve == gspm_pkg::CURVE_ROOT8) begin
            n = cfg_curve;
            for (int i = 0; i < n; i++) w = int_sqrt(w << 16);
        end else if (cfg_curve == gspm_pkg::CURVE_SQUARE || cfg_curve == gspm_pkg::CURVE_POW4
                     || cfg_curve == gspm_pkg::CURVE_POW8) begin
            n = cfg_curve - 3;
            for (int i = 0; i < n; i++) w = (w * w) >> 16;
        end
        return 16'((w * cfg_scale) >> 16);
    endfunction

    // gain, clamp and peak tracking for one accepted word
    function automatic t_out_word predict_word(input t_in_word iw);
        t_out_word ow;
        logic [15:0] raw;
        logic        neg;
        logic [31:0] mag;
        logic [14:0] fs;
        logic [47:0] prod;
        logic [15:0] g;
        raw = iw.sample;
        if (cfg_mode == gspm_pkg::MODE_NARROW) begin
            raw = {8'd0, raw[7:0]};
            neg = raw[7];
            mag = neg ? 32'h100 - raw : raw;
            fs = gspm_pkg::FS_NARROW;
        end else begin
            neg = raw[15];
            mag = neg ? 32'h10000 - raw : raw;
            fs = gspm_pkg::FS_WIDE;
        end
        g = (cfg_gain == 0) ? gspm_pkg::GAIN_UNITY : cfg_gain;
        prod = (48'(mag) * g) >> 8;
        if (prod > fs) prod = fs;
        if (prod[14:0] > frame_peak) frame_peak = prod[14:0];
        ow.level = 16'd0;
        if (iw.last) begin
            ow.level = peak_level_of(frame_peak, fs);
            frame_peak = 0;
        end
        ow.sample = neg ? 16'(-prod) : prod[15:0];
        ow.last = iw.last;
        return ow;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("word %0d: %s got %0d expected %0d", words_checked, what, got, want);
    endtask

    // driver: present queued words, change at falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_words[0].sample;
                s_axis_tlast  <= pending_words[0].last;
                void'(pending_words.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // prediction happens on input acceptance so register copies stay in step
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            expected_words.push_back(predict_word({s_axis_tdata, s_axis_tlast}));
            words_sent++;
        end
    end

    // monitor: compare each accepted output word
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, tdata", m_axis_tdata, 0);
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[15:0] !== want.sample)
                    report_mismatch("out_sample", $signed(m_axis_tdata[15:0]),
                                    $signed(want.sample));
                if (m_axis_tlast !== want.last)
                    report_mismatch("out_last", m_axis_tlast, want.last);
                if (m_axis_tdata[31:16] !== want.level)
                    report_mismatch("peak_level", m_axis_tdata[31:16], want.level);
                if (want.last) frames_checked++;
            end
            words_checked++;
        end
    end

    // APB write; predictor copy updated at the same edge
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            gspm_pkg::REG_GAIN:       cfg_gain = value;
            gspm_pkg::REG_WIDTH_MODE: cfg_mode = value[0];
            gspm_pkg::REG_CURVE:      cfg_curve = value[2:0];
            default:                  cfg_scale = value;
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // wait for the pipe to drain, plus the worst frame-end latency
    task automatic drain;
        while (pending_words.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic queue_word(input logic [15:0] s, input logic l);
        t_in_word w;
        w.sample = s;
        w.last = l;
        pending_words.push_back(w);
    endtask

    // random frames; mostly short, sometimes near full scale
    task automatic queue_random(input int count);
        int left;
        left = count;
        while (left > 0) begin
            int len;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && left > 0; i++) begin
                logic [15:0] s;
                case ($urandom_range(3))
                    0: s = 16'($urandom);
                    1: s = 16'($urandom_range(255) - 128);
                    2: s = ($urandom_range(1)) ? 16'(16'h8000 + $urandom_range(15))
                                               : 16'(16'h7FFF - $urandom_range(15));
                    default: s = 16'($urandom_range(4095) - 2048);
                endcase
                left--;
                queue_word(s, (i == len - 1) || left == 0);
            end
        end
    endtask

    task automatic random_config;
        logic [15:0] g;
        case ($urandom_range(4))
            0: g = 0;
            1: g = 16'hFFFF;
            2: g = 16'($urandom_range(64, 512));
            default: g = 16'($urandom);
        endcase
        write_reg(gspm_pkg::REG_GAIN, g);
        write_reg(gspm_pkg::REG_WIDTH_MODE, 16'($urandom_range(1)));
        write_reg(gspm_pkg::REG_CURVE, 16'($urandom_range(7)));
        write_reg(gspm_pkg::REG_PEAK_SCALE, ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom));
    endtask

    initial begin
        errors = 0; words_sent = 0; words_checked = 0; frames_checked = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0; m_axis_tready = 0;
        cfg_gain = gspm_pkg::GAIN_UNITY; cfg_mode = gspm_pkg::MODE_RESET;
        cfg_curve = gspm_pkg::CURVE_RESET;
        cfg_scale = gspm_pkg::PEAK_SCALE_INIT; frame_peak = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset settings, field extremes, most negative value
        queue_word(16'h7FFF, 0); queue_word(16'h8000, 0); queue_word(16'h0000, 0);
        queue_word(16'hFFFF, 1); queue_word(16'h0001, 1);
        drain();
        // narrow mode, gain zero, high bits ignored, max scale
        write_reg(gspm_pkg::REG_WIDTH_MODE, 0); write_reg(gspm_pkg::REG_GAIN, 0);
        write_reg(gspm_pkg::REG_PEAK_SCALE, 16'hFFFF);
        queue_word(16'h5A80, 0); queue_word(16'hA57F, 1); queue_word(16'h0040, 1);
        drain();
        // each curve incl. unused code, max gain saturating
        write_reg(gspm_pkg::REG_GAIN, 16'hFFFF); write_reg(gspm_pkg::REG_WIDTH_MODE, 1);
        for (int c = 0; c < 8; c++) begin
            write_reg(gspm_pkg::REG_CURVE, 16'(c));
            queue_word(16'h0123, 0); queue_word(16'hFF00, 1);
            queue_word(16'h0000, 1);
            drain();
        end
        write_reg(gspm_pkg::REG_PEAK_SCALE, 0); write_reg(gspm_pkg::REG_GAIN, 16'd1);
        queue_word(16'h7FFF, 1);
        drain();

        // random phases with varied idling
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            random_config();
            queue_random(95);
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        drain();

        $display("%0d words sent, %0d checked, %0d frame peaks, all curves and both modes",
                 words_sent, words_checked, frames_checked);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // timeout guard
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
src/gspm_pkg.sv
src/gspm_front.sv
src/gspm_queue.sv
src/gspm_back.sv
src/gain_saturate_peak_meter.sv
sim/tb_top.sv
